// File: src/sfb_pkg.sv
// ----------------------------------------------------------------------------
// sfb_pkg
// Shared types, constants and the CRC-16 helper for the serial frame builder.
// ----------------------------------------------------------------------------
package sfb_pkg;

  localparam int unsigned MAX_PAYLOAD        = 250;
  localparam int unsigned FRAME_BUFFER_BYTES = 256;

  localparam logic [7:0]  FLAG_BYTE     = 8'h7E;
  localparam logic [7:0]  ESC_BYTE      = 8'h7D;
  localparam logic [7:0]  ESC_XOR       = 8'h20;
  localparam logic [7:0]  REVISION      = 8'h01;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY_REFL = 16'h8408;

  // Frame bytes counted per packet; the limit is where an abort is raised.
  localparam int unsigned FBO_W       = 9;
  localparam logic [FBO_W-1:0] FRAME_LIMIT = FBO_W'(FRAME_BUFFER_BYTES - 4);
  localparam logic [FBO_W-1:0] HDR_BYTES   = FBO_W'(3);
  localparam logic [7:0]  MAX_LEN     = 8'(MAX_PAYLOAD);

  // Depth of the queue between the front and back halves.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    ST_FRAME    = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_ABORT    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_SEND    = 2'd1,
    MODE_SWALLOW = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    PH_ERROR,
    PH_FLAG,
    PH_REV,
    PH_LEN,
    PH_ESC,
    PH_DATA,
    PH_FCS_HI,
    PH_FCS_LO,
    PH_CLOSE,
    PH_ABORT
  } phase_e;

  // One classified input byte, as handed from the front to the back.
  typedef struct packed {
    logic        err;
    logic        hdr;
    logic [7:0]  len;
    logic [7:0]  data;
    logic        esc;
    logic        abort;
    logic        tail;
    logic [15:0] crc;
  } desc_t;

  typedef struct packed {
    logic [7:0] out_byte;
    status_e    status;
    logic       frame_end;
    logic       last_of_run;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // The revision byte is fixed, so its CRC step is folded at elaboration.
  localparam logic [15:0] CRC_AFTER_REV = crc_byte(CRC_INIT, REVISION);

endpackage

// File: src/sfb_in_if.sv
// ----------------------------------------------------------------------------
// sfb_in_if
// Input channel: one unescaped packet byte with the packet length.
// ----------------------------------------------------------------------------
interface sfb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [7:0] packet_length;

  modport source (output valid, output data_byte, output packet_length, input ready);
  modport sink (input valid, input data_byte, input packet_length, output ready);
endinterface

// File: src/sfb_out_if.sv
// ----------------------------------------------------------------------------
// sfb_out_if
// Output channel: one frame byte or error result per request.
// ----------------------------------------------------------------------------
interface sfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       frame_end;
  logic       last_of_run;

  modport source (output valid, output out_byte, output status, output frame_end,
                  output last_of_run, input ready);
  modport sink (input valid, input out_byte, input status, input frame_end,
                input last_of_run, output ready);
endinterface

// File: src/sfb_fifo.sv
// ----------------------------------------------------------------------------
// sfb_fifo
// Short descriptor queue between the front and back halves.
// ----------------------------------------------------------------------------
module sfb_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sfb_pkg::desc_t push_desc_i,
  input  logic           pop_i,
  output sfb_pkg::desc_t head_o,
  output logic           empty_o,
  output logic           full_o
);
  import sfb_pkg::*;

  desc_t              mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_AW:0]   count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// File: src/sfb_front.sv
// ----------------------------------------------------------------------------
// sfb_front
// Accepts packet bytes, tracks packet state and the FCS, and classifies
// each byte into a descriptor of the results it causes.
// ----------------------------------------------------------------------------
module sfb_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  sfb_in_if.sink         in_i,
  input  logic           full_i,
  output logic           push_o,
  output sfb_pkg::desc_t push_desc_o
);
  import sfb_pkg::*;

  mode_e             mode_q, mode_d;
  logic [7:0]        pos_q, pos_d;
  logic [7:0]        len_q, len_d;
  logic [15:0]       crc_q, crc_d;
  logic [FBO_W-1:0]  fbo_q, fbo_d;

  logic              accept;
  logic              start;
  logic              is_esc;
  logic [15:0]       crc_base;
  logic [15:0]       crc_new;
  logic [FBO_W-1:0]  fbo_new;
  logic [7:0]        pos_new;
  logic [7:0]        len_cur;
  logic              done;
  logic              over;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign start      = (mode_q != MODE_SEND) && (mode_q != MODE_SWALLOW);
  assign is_esc     = (in_i.data_byte == FLAG_BYTE) || (in_i.data_byte == ESC_BYTE);

  // On the first byte the header CRC steps come before the data step.
  assign crc_base = start ? crc_byte(CRC_AFTER_REV, in_i.packet_length) : crc_q;
  assign crc_new  = crc_byte(crc_base, in_i.data_byte);
  assign fbo_new  = (start ? HDR_BYTES : fbo_q) + (is_esc ? FBO_W'(2) : FBO_W'(1));
  assign len_cur  = start ? in_i.packet_length : len_q;
  assign pos_new  = (start ? 8'd0 : pos_q) + 8'd1;
  assign done     = (pos_new >= len_cur);
  assign over     = (fbo_new >= FRAME_LIMIT);

  always_comb begin
    mode_d      = mode_q;
    pos_d       = pos_q;
    len_d       = len_q;
    crc_d       = crc_q;
    fbo_d       = fbo_q;
    push_o      = 1'b0;
    push_desc_o = '0;
    push_desc_o.len  = in_i.packet_length;
    push_desc_o.data = in_i.data_byte;
    push_desc_o.esc  = is_esc;
    push_desc_o.crc  = crc_new;
    if (accept) begin
      priority if (mode_q == MODE_SWALLOW) begin
        pos_d  = pos_q + 8'd1;
        mode_d = (pos_d >= len_q) ? MODE_IDLE : MODE_SWALLOW;
      end else if (start && (in_i.packet_length == 8'd0)) begin
        push_o          = 1'b1;
        push_desc_o.err = 1'b1;
        len_d  = 8'd0;
        pos_d  = 8'd0;
        crc_d  = CRC_INIT;
        fbo_d  = '0;
        mode_d = MODE_IDLE;
      end else if (start && (in_i.packet_length > MAX_LEN)) begin
        // The rest of an oversized packet is dropped without results.
        push_o          = 1'b1;
        push_desc_o.err = 1'b1;
        len_d  = in_i.packet_length;
        pos_d  = 8'd1;
        crc_d  = CRC_INIT;
        fbo_d  = '0;
        mode_d = MODE_SWALLOW;
      end else begin
        push_o            = 1'b1;
        push_desc_o.hdr   = start;
        push_desc_o.abort = over;
        push_desc_o.tail  = !over && done;
        len_d  = len_cur;
        pos_d  = pos_new;
        crc_d  = crc_new;
        fbo_d  = fbo_new;
        if (done) begin
          mode_d = MODE_IDLE;
        end else begin
          mode_d = over ? MODE_SWALLOW : MODE_SEND;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      pos_q  <= '0;
      len_q  <= '0;
      crc_q  <= CRC_INIT;
      fbo_q  <= '0;
    end else begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      len_q  <= len_d;
      crc_q  <= crc_d;
      fbo_q  <= fbo_d;
    end
  end

endmodule

// File: src/sfb_back.sv
// ----------------------------------------------------------------------------
// sfb_back
// Expands descriptors into frame bytes and error results, one per cycle
// while the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module sfb_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sfb_pkg::desc_t head_i,
  input  logic           empty_i,
  output logic           pop_o,
  sfb_out_if.source      out_o
);
  import sfb_pkg::*;

  logic    busy_q, busy_d;
  desc_t   desc_q, desc_d;
  phase_e  phase_q, phase_d;
  logic    valid_q, valid_d;
  result_t res_q, res_d;

  desc_t   cur;
  phase_e  cur_phase;
  phase_e  next_phase;
  result_t res;
  logic    out_free;
  logic    fire;

  assign out_o.valid       = valid_q;
  assign out_o.out_byte    = res_q.out_byte;
  assign out_o.status      = res_q.status;
  assign out_o.frame_end   = res_q.frame_end;
  assign out_o.last_of_run = res_q.last_of_run;

  // When idle, the queue head is worked on directly to avoid a bubble.
  assign cur = busy_q ? desc_q : head_i;

  always_comb begin
    if (busy_q) begin
      cur_phase = phase_q;
    end else if (head_i.err) begin
      cur_phase = PH_ERROR;
    end else if (head_i.hdr) begin
      cur_phase = PH_FLAG;
    end else if (head_i.esc) begin
      cur_phase = PH_ESC;
    end else begin
      cur_phase = PH_DATA;
    end
  end

  always_comb begin
    res            = '0;
    res.status     = ST_FRAME;
    next_phase     = cur_phase;
    unique case (cur_phase)
      PH_ERROR: begin
        res.status      = ST_TOO_LONG;
        res.frame_end   = 1'b1;
        res.last_of_run = 1'b1;
      end
      PH_FLAG: begin
        res.out_byte = FLAG_BYTE;
        next_phase   = PH_REV;
      end
      PH_REV: begin
        res.out_byte = REVISION;
        next_phase   = PH_LEN;
      end
      PH_LEN: begin
        res.out_byte = cur.len;
        next_phase   = cur.esc ? PH_ESC : PH_DATA;
      end
      PH_ESC: begin
        res.out_byte = ESC_BYTE;
        next_phase   = PH_DATA;
      end
      PH_DATA: begin
        res.out_byte = cur.esc ? (cur.data ^ ESC_XOR) : cur.data;
        if (cur.abort) begin
          next_phase = PH_ABORT;
        end else if (cur.tail) begin
          next_phase = PH_FCS_HI;
        end else begin
          res.last_of_run = 1'b1;
        end
      end
      PH_FCS_HI: begin
        res.out_byte = cur.crc[15:8];
        next_phase   = PH_FCS_LO;
      end
      PH_FCS_LO: begin
        res.out_byte = cur.crc[7:0];
        next_phase   = PH_CLOSE;
      end
      PH_CLOSE: begin
        res.out_byte    = FLAG_BYTE;
        res.frame_end   = 1'b1;
        res.last_of_run = 1'b1;
      end
      PH_ABORT: begin
        res.status      = ST_ABORT;
        res.frame_end   = 1'b1;
        res.last_of_run = 1'b1;
      end
      default: begin
        res.last_of_run = 1'b1;
      end
    endcase
  end

  assign out_free = !valid_q || out_o.ready;
  assign fire     = out_free && (busy_q || !empty_i);
  assign pop_o    = fire && !busy_q;

  always_comb begin
    busy_d  = busy_q;
    desc_d  = desc_q;
    phase_d = phase_q;
    valid_d = valid_q;
    res_d   = res_q;
    if (fire) begin
      valid_d = 1'b1;
      res_d   = res;
      if (res.last_of_run) begin
        busy_d = 1'b0;
      end else begin
        busy_d  = 1'b1;
        desc_d  = cur;
        phase_d = next_phase;
      end
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= PH_FLAG;
      valid_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      valid_q <= valid_d;
    end
  end

endmodule

// File: src/serial_frame_builder_crc16_stuffing_core.sv
// ----------------------------------------------------------------------------
// serial_frame_builder_crc16_stuffing_core
// Serial frame builder with byte stuffing and a CRC-16 frame check sequence.
// ----------------------------------------------------------------------------
// Packet bytes enter on in_i, with the packet length sampled on the first
// byte of each packet. Each request on in_i is classified combinationally
// and queued; the output side then sends one result per cycle on out_o
// while out_o is not stalled. A plain data byte causes one result, an
// escaped one two, plus three for the header on the first byte and three
// for the FCS and closing flag on the last. The output port is the limit
// on throughput; the input accepts back to back while the four-entry
// queue has room. A length of zero or above 250 gives a single error result
// and the rest of that packet is dropped; an escaped frame reaching the
// frame buffer limit gives an abort result in place of the FCS and flag.
// ----------------------------------------------------------------------------
module serial_frame_builder_crc16_stuffing_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  sfb_in_if.sink    in_i,
  sfb_out_if.source out_o
);
  import sfb_pkg::*;

  logic  push;
  desc_t push_desc;
  logic  pop;
  desc_t head;
  logic  empty;
  logic  full;

  sfb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .full_i      (full),
    .push_o      (push),
    .push_desc_o (push_desc)
  );

  sfb_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty),
    .full_o      (full)
  );

  sfb_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
